FILE: design/assert_macros.svh
// Assertion macros used by the checker file pfb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pfb_pkg.sv
// Package with constants, words and codes of the page framebuffer fill engine.
`timescale 1ns / 1ps
package pfb_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  localparam int BYTE_W   = 8;
  localparam int ACTION_W = 2;
  localparam int POS_X_W  = 7;
  localparam int POS_Y_W  = 6;
  localparam int PAGE_W   = POS_Y_W - 3;
  localparam int X_END_W  = POS_X_W + 1;
  localparam int Y_END_W  = POS_Y_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] SCREEN_WIDTH_A = ADDR_W'(SCREEN_WIDTH);
  localparam logic [BYTE_W-1:0] BYTE_ONES      = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;

  // Action codes of the command word.
  localparam logic [ACTION_W-1:0] ACT_FILL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TEST = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_X_W-1:0]  pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [POS_X_W-1:0]  rect_width;
    logic [POS_Y_W-1:0]  rect_height;
    logic                ink;
  } cmd_word_t;

  typedef struct packed {
    logic              pixel_on;
    logic [BYTE_W-1:0] page_byte;
    logic              outside;
  } rsp_word_t;

  typedef enum logic [1:0] {
    JOB_FILL,
    JOB_TEST,
    JOB_READ
  } job_kind_t;

  // Classified job: addr is the first page base for a fill, the byte address for a query.
  typedef struct packed {
    job_kind_t          kind;
    logic               ink;
    logic [POS_X_W-1:0] x_first;
    logic [POS_X_W-1:0] x_last;
    logic [PAGE_W-1:0]  page_first;
    logic [PAGE_W-1:0]  page_last;
    logic [BYTE_W-1:0]  mask_first;
    logic [BYTE_W-1:0]  mask_last;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         bit_sel;
    logic               off;
  } job_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_FLUSH,
    ST_QUERY
  } back_state_t;

endpackage

FILE: design/pfb_front.sv
// Front end: accepts command words, clips rectangles and classifies them into jobs.
`timescale 1ns / 1ps
module pfb_front (
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  pfb_pkg::cmd_word_t cmd,
  input  logic               queue_full,
  input  logic               clearing,
  output logic               push,
  output pfb_pkg::job_t      job
);

  logic [pfb_pkg::X_END_W-1:0] x_end;
  logic [pfb_pkg::X_END_W-1:0] x_lim;
  logic [pfb_pkg::X_END_W-1:0] x_last_ext;
  logic [pfb_pkg::Y_END_W-1:0] y_end;
  logic [pfb_pkg::Y_END_W-1:0] y_lim;
  logic [pfb_pkg::Y_END_W-1:0] y_last_ext;
  logic [pfb_pkg::ADDR_W-1:0]  page_base;
  logic                        empty;
  logic                        keep;

  assign cmd_stall = queue_full | clearing;

  always_comb begin
    x_end = {1'b0, cmd.pos_x} + {1'b0, cmd.rect_width};
    y_end = {1'b0, cmd.pos_y} + {1'b0, cmd.rect_height};
    x_lim = (x_end > pfb_pkg::X_END_W'(pfb_pkg::SCREEN_WIDTH)) ?
            pfb_pkg::X_END_W'(pfb_pkg::SCREEN_WIDTH) : x_end;
    y_lim = (y_end > pfb_pkg::Y_END_W'(pfb_pkg::SCREEN_HEIGHT)) ?
            pfb_pkg::Y_END_W'(pfb_pkg::SCREEN_HEIGHT) : y_end;
    x_last_ext = x_lim - pfb_pkg::X_END_W'(1);
    y_last_ext = y_lim - pfb_pkg::Y_END_W'(1);
    empty = (cmd.rect_width == '0) || (cmd.rect_height == '0) ||
            ({1'b0, cmd.pos_x} >= x_lim) || ({1'b0, cmd.pos_y} >= y_lim);
    page_base = pfb_pkg::ADDR_W'(cmd.pos_y[pfb_pkg::POS_Y_W-1:3]) * pfb_pkg::SCREEN_WIDTH_A;

    job.kind       = pfb_pkg::JOB_FILL;
    job.ink        = cmd.ink;
    job.x_first    = cmd.pos_x;
    job.x_last     = x_last_ext[pfb_pkg::POS_X_W-1:0];
    job.page_first = cmd.pos_y[pfb_pkg::POS_Y_W-1:3];
    job.page_last  = y_last_ext[pfb_pkg::POS_Y_W-1:3];
    job.mask_first = pfb_pkg::BYTE_ONES << cmd.pos_y[2:0];
    job.mask_last  = pfb_pkg::BYTE_ONES >> (3'd7 - y_last_ext[2:0]);
    job.addr       = page_base;
    job.bit_sel    = cmd.pos_y[2:0];
    job.off        = ({1'b0, cmd.pos_x} >= pfb_pkg::X_END_W'(pfb_pkg::SCREEN_WIDTH)) ||
                     ({1'b0, cmd.pos_y} >= pfb_pkg::Y_END_W'(pfb_pkg::SCREEN_HEIGHT));
    keep           = 1'b0;

    // Empty or fully clipped fills and the unused action are taken and dropped here.
    unique case (cmd.action)
      pfb_pkg::ACT_FILL: begin
        keep = !empty;
      end
      pfb_pkg::ACT_TEST: begin
        keep      = 1'b1;
        job.kind  = pfb_pkg::JOB_TEST;
        job.addr  = page_base + pfb_pkg::ADDR_W'(cmd.pos_x);
      end
      pfb_pkg::ACT_READ: begin
        keep      = 1'b1;
        job.kind  = pfb_pkg::JOB_READ;
        job.addr  = page_base + pfb_pkg::ADDR_W'(cmd.pos_x);
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    push = cmd_valid && !cmd_stall && keep;
  end

endmodule

FILE: design/pfb_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module pfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pfb_pkg::job_t head
);

  pfb_pkg::job_t               slots [pfb_pkg::QUEUE_DEPTH];
  logic [pfb_pkg::QPTR_W-1:0]  wr_ptr;
  logic [pfb_pkg::QPTR_W-1:0]  rd_ptr;
  logic [pfb_pkg::QCNT_W-1:0]  count;

  assign full       = (count == pfb_pkg::QCNT_W'(pfb_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pfb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pfb_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + pfb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pfb_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: design/pfb_back.sv
// Back end: frame store, clearing pass, masked fill sweep and pixel or byte queries.
`timescale 1ns / 1ps
module pfb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  pfb_pkg::job_t      head,
  output logic               pop,
  output logic               clearing,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pfb_pkg::rsp_word_t rsp
);

  logic [pfb_pkg::BYTE_W-1:0] mem [pfb_pkg::STORE_DEPTH];

  pfb_pkg::back_state_t        state, state_next;
  pfb_pkg::job_t               job, job_next;
  logic [pfb_pkg::POS_X_W-1:0] col, col_next;
  logic [pfb_pkg::PAGE_W-1:0]  page, page_next;
  logic [pfb_pkg::ADDR_W-1:0]  base, base_next;
  logic [pfb_pkg::ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic                        rmw_valid, rmw_valid_next;
  logic [pfb_pkg::ADDR_W-1:0]  rmw_addr, rmw_addr_next;
  logic [pfb_pkg::BYTE_W-1:0]  rmw_mask, rmw_mask_next;
  logic                        rsp_valid_next;
  pfb_pkg::rsp_word_t          rsp_next;
  logic [pfb_pkg::BYTE_W-1:0]  rd_data;

  logic                        rd_en;
  logic [pfb_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [pfb_pkg::ADDR_W-1:0]  wr_addr;
  logic [pfb_pkg::BYTE_W-1:0]  wr_data;
  logic [pfb_pkg::ADDR_W-1:0]  fill_addr;
  logic [pfb_pkg::BYTE_W-1:0]  fill_mask;

  assign clearing = (state == pfb_pkg::ST_CLEAR);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfb_pkg::ST_CLEAR;
      clr_addr  <= '0;
      rmw_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      rmw_valid <= rmw_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job      <= job_next;
    col      <= col_next;
    page     <= page_next;
    base     <= base_next;
    rmw_addr <= rmw_addr_next;
    rmw_mask <= rmw_mask_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    fill_addr = base + pfb_pkg::ADDR_W'(col);
    fill_mask = ((page == job.page_first) ? job.mask_first : pfb_pkg::BYTE_ONES) &
                ((page == job.page_last)  ? job.mask_last  : pfb_pkg::BYTE_ONES);

    state_next     = state;
    job_next       = job;
    col_next       = col;
    page_next      = page;
    base_next      = base;
    clr_addr_next  = clr_addr;
    rmw_valid_next = 1'b0;
    rmw_addr_next  = rmw_addr;
    rmw_mask_next  = rmw_mask;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = fill_addr;

    // The second half of a read-modify-write lands in the cycle after its read.
    wr_en   = rmw_valid;
    wr_addr = rmw_addr;
    wr_data = job.ink ? (rd_data | rmw_mask) : (rd_data & ~rmw_mask);

    unique case (state)
      pfb_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = pfb_pkg::BYTE_ZERO;
        clr_addr_next = clr_addr + pfb_pkg::ADDR_W'(1);
        if (clr_addr == pfb_pkg::ADDR_W'(pfb_pkg::STORE_DEPTH - 1)) begin
          state_next = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.kind == pfb_pkg::JOB_FILL) begin
            pop        = 1'b1;
            job_next   = head;
            col_next   = head.x_first;
            page_next  = head.page_first;
            base_next  = head.addr;
            state_next = pfb_pkg::ST_FILL;
          end else if (!rsp_valid || !rsp_stall) begin
            // The result register is free by the time the read data returns.
            pop        = 1'b1;
            job_next   = head;
            rd_en      = 1'b1;
            rd_addr    = head.addr;
            state_next = pfb_pkg::ST_QUERY;
          end
        end
      end
      pfb_pkg::ST_FILL: begin
        rd_en          = 1'b1;
        rmw_valid_next = 1'b1;
        rmw_addr_next  = fill_addr;
        rmw_mask_next  = fill_mask;
        if (col == job.x_last) begin
          col_next = job.x_first;
          if (page == job.page_last) begin
            state_next = pfb_pkg::ST_FLUSH;
          end else begin
            page_next = page + pfb_pkg::PAGE_W'(1);
            base_next = base + pfb_pkg::SCREEN_WIDTH_A;
          end
        end else begin
          col_next = col + pfb_pkg::POS_X_W'(1);
        end
      end
      pfb_pkg::ST_FLUSH: begin
        state_next = pfb_pkg::ST_IDLE;
      end
      pfb_pkg::ST_QUERY: begin
        rsp_valid_next     = 1'b1;
        rsp_next.outside   = job.off;
        rsp_next.pixel_on  = !job.off && (job.kind == pfb_pkg::JOB_TEST) &&
                             rd_data[job.bit_sel];
        rsp_next.page_byte = (!job.off && (job.kind == pfb_pkg::JOB_READ)) ?
                             rd_data : pfb_pkg::BYTE_ZERO;
        state_next         = pfb_pkg::ST_IDLE;
      end
      default: begin
        state_next = pfb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/page_framebuffer_fill_engine_unit.sv
// Top level of the page framebuffer fill engine.
// A query goes through the queue, store read and result register; the back end takes one at a time.
// In the back end a fill sweeps every column of each page it covers, one page byte per cycle
// through the frame store's single read and single write port.
// After reset a clearing pass writes all 504 bytes to zero; cmd_stall holds high.
`timescale 1ns / 1ps
module page_framebuffer_fill_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  pfb_pkg::cmd_word_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pfb_pkg::rsp_word_t rsp
);

  logic          push;
  pfb_pkg::job_t push_job;
  logic          queue_full;
  logic          clearing;
  logic          pop;
  logic          head_valid;
  pfb_pkg::job_t head;

  pfb_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .job        (push_job)
  );

  pfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

FILE: design/pfb_checker.sv
// Port-level checker for the page framebuffer fill engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfb_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input pfb_pkg::cmd_word_t cmd,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input pfb_pkg::rsp_word_t rsp
);

  // Reset empties the result register and starts the clearing pass.
  `ASSERT_ALWAYS(a_reset_quiet, rst |=> !rsp_valid && cmd_stall, "reset did not quiet the ports")

  `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled word moved")

  // An off-screen query reports zeros in both value fields.
  `ASSERT_CLK(a_outside_zero, rsp_valid && rsp.outside |-> !rsp.pixel_on && rsp.page_byte == 8'd0, "outside word carries data")

  // A test never reports a byte and a read never reports a pixel.
  `ASSERT_CLK(a_one_kind, rsp_valid && rsp.pixel_on |-> rsp.page_byte == 8'd0, "word mixes pixel and byte")

endmodule

bind page_framebuffer_fill_engine_unit pfb_checker u_checker (.*);
